// ===== rtl/core/i2r_pkg.sv =====
// ----------------------------------------------------------------------------
// i2r_pkg
// Shared types, constants and helper functions for the integer to Roman
// numeral encoder.
// ----------------------------------------------------------------------------
package i2r_pkg;

    localparam int NUM_W      = 12;
    localparam int SYM_W      = 8;
    localparam int DIG_W      = 4;
    localparam int NUM_DIGITS = 4;
    localparam int POS_W      = 2;
    localparam int STEP_W     = 2;
    localparam int LEN_W      = 3;

    localparam logic [NUM_W-1:0] NUM_MAX = 12'd3999;

    // power of two keeps the pointers wrapping on their own
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SYM_W-1:0] SYM_NONE = 8'h00;
    localparam logic [SYM_W-1:0] SYM_I    = 8'h49;
    localparam logic [SYM_W-1:0] SYM_V    = 8'h56;
    localparam logic [SYM_W-1:0] SYM_X    = 8'h58;
    localparam logic [SYM_W-1:0] SYM_L    = 8'h4C;
    localparam logic [SYM_W-1:0] SYM_C    = 8'h43;
    localparam logic [SYM_W-1:0] SYM_D    = 8'h44;
    localparam logic [SYM_W-1:0] SYM_M    = 8'h4D;

    localparam logic [POS_W-1:0] POS_UNITS    = 2'd0;
    localparam logic [POS_W-1:0] POS_TENS     = 2'd1;
    localparam logic [POS_W-1:0] POS_HUNDREDS = 2'd2;
    localparam logic [POS_W-1:0] POS_THOUSAND = 2'd3;

    typedef enum logic [1:0] {
        K_ONE,
        K_FIVE,
        K_TEN
    } t_kind;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } t_back_state;

    // one queued transaction: bad flag and decimal digits, units at index 0
    typedef struct packed {
        logic                             bad;
        logic [NUM_DIGITS-1:0][DIG_W-1:0] dig;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
    } t_sel;

    // number of characters one decimal digit turns into
    function automatic logic [LEN_W-1:0] dig_len(input logic [DIG_W-1:0] d);
        logic [LEN_W-1:0] len;
        case (d)
            4'd1, 4'd2, 4'd3:        len = LEN_W'(d);
            4'd4, 4'd9:              len = 3'd2;
            4'd5, 4'd6, 4'd7, 4'd8:  len = LEN_W'(d - 4'd4);
            default:                 len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic t_kind char_kind(input logic [DIG_W-1:0] d,
                                        input logic [STEP_W-1:0] step);
        t_kind k;
        case (d)
            4'd4:                    k = (step == '0) ? K_ONE : K_FIVE;
            4'd9:                    k = (step == '0) ? K_ONE : K_TEN;
            4'd5, 4'd6, 4'd7, 4'd8:  k = (step == '0) ? K_FIVE : K_ONE;
            default:                 k = K_ONE;
        endcase
        return k;
    endfunction

    function automatic logic [SYM_W-1:0] letter(input logic [POS_W-1:0] pos,
                                                input t_kind kind);
        logic [SYM_W-1:0] s;
        case (pos)
            POS_UNITS:    s = (kind == K_ONE) ? SYM_I : (kind == K_FIVE) ? SYM_V : SYM_X;
            POS_TENS:     s = (kind == K_ONE) ? SYM_X : (kind == K_FIVE) ? SYM_L : SYM_C;
            POS_HUNDREDS: s = (kind == K_ONE) ? SYM_C : (kind == K_FIVE) ? SYM_D : SYM_M;
            POS_THOUSAND: s = SYM_M;
            default:      s = SYM_NONE;
        endcase
        return s;
    endfunction

    // highest set position in a digit mask
    function automatic t_sel hi_nz(input logic [NUM_DIGITS-1:0] mask);
        t_sel r;
        r = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (mask[i]) begin
                r.found = 1'b1;
                r.pos   = POS_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/i2r_front.sv =====
// ----------------------------------------------------------------------------
// i2r_front
// Accepts numbers, flags out-of-range values and splits the rest into
// decimal digits over two pipeline stages.
// ----------------------------------------------------------------------------
module i2r_front import i2r_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [NUM_W-1:0] i_number,
    input  t_q_status  i_q_stat,
    output logic       o_push,
    output t_item      o_item
);

    // stage 1: thousands split off
    logic             r_v1;
    logic             r_bad1;
    logic [DIG_W-1:0] r_th1;
    logic [9:0]       r_rem1;
    logic             n_bad1;
    logic [DIG_W-1:0] n_th1;
    logic [9:0]       n_rem1;

    // stage 2: hundreds split off
    logic             r_v2;
    logic             r_bad2;
    logic [DIG_W-1:0] r_th2;
    logic [DIG_W-1:0] r_hu2;
    logic [6:0]       r_rem2;
    logic [DIG_W-1:0] n_hu2;
    logic [6:0]       n_rem2;
    logic [9:0]       sub_hu;

    logic [DIG_W-1:0] te;
    logic [DIG_W-1:0] un;
    logic [6:0]       sub_te;

    logic rdy1;
    logic rdy2;
    logic acc;

    assign rdy2    = !r_v2 || !i_q_stat.full;
    assign rdy1    = !r_v1 || rdy2;
    assign o_stall = !rdy1;
    assign acc     = i_valid && rdy1;

    always_comb begin
        n_bad1 = (i_number == '0) || (i_number > NUM_MAX);
        if (i_number >= 12'd3000) begin
            n_th1  = 4'd3;
            n_rem1 = 10'(i_number - 12'd3000);
        end else if (i_number >= 12'd2000) begin
            n_th1  = 4'd2;
            n_rem1 = 10'(i_number - 12'd2000);
        end else if (i_number >= 12'd1000) begin
            n_th1  = 4'd1;
            n_rem1 = 10'(i_number - 12'd1000);
        end else begin
            n_th1  = 4'd0;
            n_rem1 = i_number[9:0];
        end
    end

    always_comb begin
        n_hu2  = '0;
        sub_hu = '0;
        for (int k = 1; k <= 9; k++) begin
            if (r_rem1 >= 10'(k * 100)) begin
                n_hu2  = DIG_W'(k);
                sub_hu = 10'(k * 100);
            end
        end
        n_rem2 = 7'(r_rem1 - sub_hu);
    end

    always_comb begin
        te     = '0;
        sub_te = '0;
        for (int k = 1; k <= 9; k++) begin
            if (r_rem2 >= 7'(k * 10)) begin
                te     = DIG_W'(k);
                sub_te = 7'(k * 10);
            end
        end
        un = DIG_W'(r_rem2 - sub_te);
    end

    assign o_push     = r_v2 && !i_q_stat.full;
    assign o_item.bad = r_bad2;
    assign o_item.dig = {r_th2, r_hu2, te, un};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= acc;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_bad1 <= n_bad1;
            r_th1  <= n_th1;
            r_rem1 <= n_rem1;
        end
        if (rdy2 && r_v1) begin
            r_bad2 <= r_bad1;
            r_th2  <= r_th1;
            r_hu2  <= n_hu2;
            r_rem2 <= n_rem2;
        end
    end

endmodule

// ===== rtl/core/i2r_queue.sv =====
// ----------------------------------------------------------------------------
// i2r_queue
// Short queue of split numbers between the front and the sequencer.
// ----------------------------------------------------------------------------
module i2r_queue import i2r_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_item     i_item,
    input  logic      i_pop,
    output t_item     o_item,
    output t_q_status o_stat
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;

    assign o_stat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_item       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full |-> !i_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.empty |-> !i_pop)
        else $error("pop from empty queue");

endmodule

// ===== rtl/core/i2r_back.sv =====
// ----------------------------------------------------------------------------
// i2r_back
// Character sequencer: walks the non-zero digits of one queued number and
// emits one numeral letter per cycle into the output register while i_stall is low.
// ----------------------------------------------------------------------------
module i2r_back import i2r_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_item      i_item,
    input  t_q_status  i_q_stat,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [SYM_W-1:0] o_symbol,
    output logic       o_last,
    output logic       o_bad_input
);

    t_back_state r_state;
    t_back_state n_state;

    logic                             r_bad;
    logic [NUM_DIGITS-1:0][DIG_W-1:0] r_dig;
    logic [POS_W-1:0]                 r_pos;
    logic [STEP_W-1:0]                r_step;

    logic             r_ov;
    logic [SYM_W-1:0] r_sym;
    logic             r_last;
    logic             r_obad;

    logic [NUM_DIGITS-1:0] nz;
    logic [NUM_DIGITS-1:0] nz_new;
    logic [NUM_DIGITS-1:0] lo_mask;
    logic [DIG_W-1:0]      cur_d;
    logic [LEN_W-1:0]      cur_len;
    logic [SYM_W-1:0]      cur_sym;
    t_sel                  nxt;
    t_sel                  first;
    logic                  dig_done;
    logic                  cur_last;
    logic                  out_free;
    logic                  emit;
    logic                  pop;

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            nz[i]     = (r_dig[i] != '0);
            nz_new[i] = (i_item.dig[i] != '0);
        end
    end

    assign lo_mask  = (NUM_DIGITS'(1) << r_pos) - NUM_DIGITS'(1);
    assign nxt      = hi_nz(nz & lo_mask);
    assign first    = hi_nz(nz_new);
    assign cur_d    = r_dig[r_pos];
    assign cur_len  = dig_len(cur_d);
    assign cur_sym  = r_bad ? SYM_NONE : letter(r_pos, char_kind(cur_d, r_step));
    assign dig_done = r_bad || ({1'b0, r_step} == (cur_len - LEN_W'(1)));
    assign cur_last = r_bad || (dig_done && !nxt.found);
    assign out_free = !r_ov || !i_stall;

    // output decode
    always_comb begin
        emit = 1'b0;
        pop  = 1'b0;
        case (r_state)
            BK_IDLE: begin
                pop = !i_q_stat.empty;
            end
            BK_EMIT: begin
                emit = out_free;
                pop  = out_free && cur_last && !i_q_stat.empty;
            end
            default: begin
                emit = 1'b0;
                pop  = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (pop) n_state = BK_EMIT;
            end
            BK_EMIT: begin
                if (emit && cur_last && !pop) n_state = BK_IDLE;
            end
            default: n_state = BK_IDLE;
        endcase
    end

    assign o_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_free) begin
                r_ov <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_bad  <= i_item.bad;
            r_dig  <= i_item.dig;
            r_pos  <= first.pos;
            r_step <= '0;
        end else if (emit) begin
            if (dig_done) begin
                r_pos  <= nxt.pos;
                r_step <= '0;
            end else begin
                r_step <= r_step + 1'b1;
            end
        end
        if (emit) begin
            r_sym  <= cur_sym;
            r_last <= cur_last;
            r_obad <= r_bad;
        end
    end

    assign o_valid     = r_ov;
    assign o_symbol    = r_sym;
    assign o_last      = r_last;
    assign o_bad_input = r_obad;

    a_bad_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_input) |-> (o_symbol == SYM_NONE && o_last))
        else $error("bad transaction not a single empty symbol");

    a_good_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_bad_input) |-> (o_symbol != SYM_NONE))
        else $error("valid number gave an empty symbol");

    a_emit_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_EMIT && !r_bad) |-> (cur_d != '0))
        else $error("sequencer sits on a zero digit");

endmodule

// ===== rtl/core/integer_to_roman_encoder_top.sv =====
// ----------------------------------------------------------------------------
// integer_to_roman_encoder_top
// Converts a 12-bit binary number into its Roman numeral, one ASCII letter
// per output transaction.
// ----------------------------------------------------------------------------
// A number is taken every cycle while o_stall is low; each one yields as many
// output transactions as its numeral has letters (1 to 15, most significant
// first, o_last on the final one), or a single transaction with symbol 0 and
// o_bad_input set for 0 or values above 3999. The character sequencer emits
// one letter per cycle while i_stall is low, so sustained throughput is one
// letter per cycle; a two-stage digit splitter and a two-entry queue ahead of
// it absorb input while long numerals drain. Each number passes through both
// splitter stages, the queue and the sequencer before its first letter is shown.
module integer_to_roman_encoder_top import i2r_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [NUM_W-1:0] i_number,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [SYM_W-1:0] o_symbol,
    output logic             o_last,
    output logic             o_bad_input
);

    t_q_status q_stat;
    t_item     push_item;
    t_item     head_item;
    logic      push;
    logic      pop;

    i2r_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_number (i_number),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_item   (push_item)
    );

    i2r_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_stat  (q_stat)
    );

    i2r_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (head_item),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_symbol    (o_symbol),
        .o_last      (o_last),
        .o_bad_input (o_bad_input)
    );

endmodule

// ===== tb/sv/tb_integer_to_roman_encoder_top.sv =====
// ----------------------------------------------------------------------------
// tb_integer_to_roman_encoder_top
// Drives binary numbers into the Roman numeral encoder and checks every output
// letter, field by field, against letters spelled out locally: a short table
// of corner numbers first, then random numbers with random gaps on the input
// side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb_integer_to_roman_encoder_top;
    import i2r_pkg::*;

    localparam int STUCK_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 250;
    localparam int IDLE_PCT     = 22;

    // letter set per decimal place, units at index 0
    localparam logic [SYM_W-1:0] ONE_OF  [4] = '{SYM_I, SYM_X, SYM_C, SYM_M};
    localparam logic [SYM_W-1:0] FIVE_OF [4] = '{SYM_V, SYM_L, SYM_D, SYM_NONE};
    localparam logic [SYM_W-1:0] TEN_OF  [4] = '{SYM_X, SYM_C, SYM_M, SYM_NONE};

    typedef struct {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             bad;
        logic [NUM_W-1:0] number;
    } t_numeral_char;

    // spelled empty and out_of_range low: letters come from spell_numeral
    typedef struct {
        logic [NUM_W-1:0] number;
        string            spelled;
        bit               out_of_range;
    } t_number_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic [NUM_W-1:0] i_number = '0;
    logic             i_stall = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic [SYM_W-1:0] o_symbol;
    logic             o_last;
    logic             o_bad_input;

    t_numeral_char pending_letters[$];
    int            mismatch_count = 0;
    int            stuck_cycles = 0;
    bit            calm = 1'b0;

    t_number_row corner_rows [24] = '{
        '{12'd0,    "",                1'b1},
        '{12'd4000, "",                1'b1},
        '{12'd4095, "",                1'b1},
        '{12'd1,    "I",               1'b0},
        '{12'd3999, "MMMCMXCIX",       1'b0},
        '{12'd3888, "MMMDCCCLXXXVIII", 1'b0},
        '{12'd4,    "IV",              1'b0},
        '{12'd5,    "V",               1'b0},
        '{12'd8,    "VIII",            1'b0},
        '{12'd9,    "IX",              1'b0},
        '{12'd40,   "XL",              1'b0},
        '{12'd90,   "XC",              1'b0},
        '{12'd400,  "CD",              1'b0},
        '{12'd900,  "CM",              1'b0},
        '{12'd1000, "M",               1'b0},
        '{12'd3000, "MMM",             1'b0},
        '{12'd0,    "",                1'b1},
        '{12'd1994, "",                1'b0},
        '{12'd2748, "",                1'b0},
        '{12'd1365, "",                1'b0},
        '{12'd2730, "",                1'b0},
        '{12'd3072, "",                1'b0},
        '{12'd2047, "",                1'b0},
        '{12'd4001, "",                1'b0}
    };

    integer_to_roman_encoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_number    (i_number),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_symbol    (o_symbol),
        .o_last      (o_last),
        .o_bad_input (o_bad_input)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch: %s", msg);
        end
    endtask

    task automatic spell_numeral(input logic [NUM_W-1:0] value);
        logic [SYM_W-1:0] letters[$];
        t_numeral_char    ch;
        int               scale;
        int               digit;
        ch.number = value;
        if (value == 0 || value > NUM_MAX) begin
            ch.symbol = SYM_NONE;
            ch.last   = 1'b1;
            ch.bad    = 1'b1;
            pending_letters.push_back(ch);
        end else begin
            scale = 1000;
            for (int pos = 3; pos >= 0; pos--) begin
                digit = (int'(value) / scale) % 10;
                if (digit == 9) begin
                    letters.push_back(ONE_OF[pos]);
                    letters.push_back(TEN_OF[pos]);
                end else if (digit == 4) begin
                    letters.push_back(ONE_OF[pos]);
                    letters.push_back(FIVE_OF[pos]);
                end else begin
                    if (digit >= 5) begin
                        letters.push_back(FIVE_OF[pos]);
                    end
                    for (int k = 0; k < digit % 5; k++) begin
                        letters.push_back(ONE_OF[pos]);
                    end
                end
                scale = scale / 10;
            end
            foreach (letters[i]) begin
                ch.symbol = letters[i];
                ch.last   = (i == letters.size() - 1);
                ch.bad    = 1'b0;
                pending_letters.push_back(ch);
            end
        end
    endtask

    // rows with the numeral written out in the table, or flagged out of range
    task automatic load_spelled(input t_number_row row);
        t_numeral_char ch;
        ch.number = row.number;
        if (row.out_of_range) begin
            ch.symbol = SYM_NONE;
            ch.last   = 1'b1;
            ch.bad    = 1'b1;
            pending_letters.push_back(ch);
        end else begin
            for (int i = 0; i < row.spelled.len(); i++) begin
                ch.symbol = row.spelled[i];
                ch.last   = (i == row.spelled.len() - 1);
                ch.bad    = 1'b0;
                pending_letters.push_back(ch);
            end
        end
    endtask

    // called just after the clock rises; returns once the encoder has taken the number
    task automatic send_number(input t_number_row row);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_number <= row.number;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        if (row.out_of_range || row.spelled.len() != 0) begin
            load_spelled(row);
        end else begin
            spell_numeral(row.number);
        end
    endtask

    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin : letter_check
        t_numeral_char want;
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            if (pending_letters.size() == 0) begin
                note_mismatch($sformatf("unexpected letter %h", o_symbol));
            end else begin
                want = pending_letters.pop_front();
                if (o_symbol !== want.symbol) begin
                    note_mismatch($sformatf("number %0d symbol: expected %h got %h",
                                            want.number, want.symbol, o_symbol));
                end
                if (o_last !== want.last) begin
                    note_mismatch($sformatf("number %0d last: expected %b got %b",
                                            want.number, want.last, o_last));
                end
                if (o_bad_input !== want.bad) begin
                    note_mismatch($sformatf("number %0d bad_input: expected %b got %b",
                                            want.number, want.bad, o_bad_input));
                end
            end
        end
    end

    // any transaction on either side clears the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles == STUCK_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_number_row row;
        int          pick;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_rows[i]) begin
            send_number(corner_rows[i]);
        end

        row.spelled      = "";
        row.out_of_range = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // a stretch with back-to-back traffic on both sides
            calm = (n >= 120 && n < 170);
            pick = $urandom_range(99);
            if (pick < 6) begin
                row.number = '0;
            end else if (pick < 12) begin
                row.number = NUM_W'($urandom_range(4000, 4095));
            end else if (pick < 20) begin
                row.number = NUM_W'($urandom_range(3880, 3999));
            end else if (pick < 28) begin
                row.number = NUM_W'($urandom_range(0, 4095));
            end else begin
                row.number = NUM_W'($urandom_range(1, 3999));
            end
            send_number(row);
        end
        i_valid <= 1'b0;
        calm = 1'b0;

        while (pending_letters.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_letters.size() != 0) begin
            note_mismatch($sformatf("%0d letters never arrived", pending_letters.size()));
        end
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
